// ===== rtl/core/mbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared constants and types of the masked bit compaction unit.
// ----------------------------------------------------------------------------
package mbc_pkg;

   // Pattern table depth; block_index is taken modulo this (power of two).
   localparam int BLOCKS  = 1024;
   localparam int BLK_AW  = $clog2(BLOCKS);

   localparam int BYTE_W  = 8;
   localparam int IDX_W   = 10;
   localparam int PEND_W  = 7;
   localparam int PCNT_W  = 3;

   // Item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   // Result queue
   localparam int QDEPTH  = 2;
   localparam int QCNT_W  = 2;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [IDX_W-1:0]  out_index;
      logic              out_last;
   } rsp_item_type;

endpackage

// ===== rtl/core/mbc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc_req_if / mbc_rsp_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface mbc_req_if;
   import mbc_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [IDX_W-1:0]  block_index;
   logic [BYTE_W-1:0] byte_value;
   logic              last;

   modport source (output valid, output kind, output block_index,
                   output byte_value, output last, input ready);
   modport sink   (input valid, input kind, input block_index,
                   input byte_value, input last, output ready);
endinterface

interface mbc_rsp_if;
   import mbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [IDX_W-1:0]  out_index;
   logic              out_last;

   modport source (output valid, output out_byte, output out_index,
                   output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_index,
                   input out_last, output ready);
endinterface

// ===== rtl/core/masked_bit_compaction_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_bit_compaction_unit
// Streams data bytes through a per-block pattern table, keeps the bits at
// the pattern's set positions and packs them LSB first into output bytes.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake       item
//  --------  ----  --------------  ------------------------------------------
//  req_bus   in    valid / ready   kind, block_index, byte_value, last
//  rsp_bus   out   valid / ready   out_byte, out_index, out_last
//
//  One item per cycle sustained unless stage 1 holds. A load writes the
//  pattern memory at the accept edge; a data item reads it there, is
//  registered into stage 1 and there extracted and appended once the queue
//  has room. Each data item yields zero, one or two results (two when the
//  last item completes a byte and also leaves a partial one); those drain
//  through a two-entry result queue at one per cycle when rsp is ready.
//  Synchronous reset clears the stream state and queue; the pattern memory
//  is not cleared and holds garbage until loaded.
//  Stage 1 holds while the queue lacks room for its results; req ready
//  drops only then.
// ----------------------------------------------------------------------------
module masked_bit_compaction_unit (
   input  logic      clock,
   input  logic      reset,
   mbc_req_if.sink   req_bus,
   mbc_rsp_if.source rsp_bus
);
   import mbc_pkg::*;

   // ------------------------------------------------------------------
   // Pattern memory, one byte per block, registered read
   // ------------------------------------------------------------------
   logic [BYTE_W-1:0] pattern_mem [BLOCKS];
   logic [BYTE_W-1:0] pat_rd_ff;

   logic              req_fire;
   logic              req_data;
   logic [BLK_AW-1:0] req_addr;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign req_data = (req_bus.kind == KIND_DATA);
   assign req_addr = req_bus.block_index[BLK_AW-1:0];

   // Memory ops happen in accept order, so a load is always visible to any
   // later data item: no forwarding needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (req_data) begin
            pat_rd_ff <= pattern_mem[req_addr];
         end else begin
            pattern_mem[req_addr] <= req_bus.byte_value;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: data byte waiting on its pattern byte
   // ------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff;
   logic              s1_last_ff;
   logic              s1_adv;

   always_ff @(posedge clock) begin
      if (req_fire && req_data) begin
         s1_data_ff <= req_bus.byte_value;
         s1_last_ff <= req_bus.last;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_adv || !s1_valid_ff) begin
         s1_valid_in = req_fire && req_data;
      end
   end

   assign req_bus.ready = !s1_valid_ff || s1_adv;

   // ------------------------------------------------------------------
   // Stream state
   // ------------------------------------------------------------------
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [PCNT_W-1:0] pend_cnt_ff, pend_cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Extract: gather the data bits under the pattern, lowest first.
   logic [BYTE_W-1:0] ext;
   logic [3:0]        ext_n;

   always_comb begin
      ext   = '0;
      ext_n = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         if (pat_rd_ff[i]) begin
            ext[ext_n[2:0]] = s1_data_ff[i];
            ext_n           = ext_n + 4'd1;
         end
      end
   end

   // Append. Pending bits above pend_cnt are kept zero, so acc is clean.
   logic [14:0] acc;
   logic [14:0] rem_acc;
   logic [3:0]  total;
   logic [3:0]  rem;
   logic        full;

   assign acc     = {8'b0, pend_ff} | ({7'b0, ext} << pend_cnt_ff);
   assign total   = {1'b0, pend_cnt_ff} + ext_n;
   assign full    = total[3];   // total never exceeds 15
   assign rem     = full ? (total - 4'd8) : total;
   assign rem_acc = full ? (acc >> 8) : acc;

   // Results of this item
   rsp_item_type res_a, res_b;
   logic [1:0]   n_res;
   logic         flush;

   assign flush = s1_last_ff && (rem != 4'd0);

   always_comb begin
      res_b.out_byte  = rem_acc[BYTE_W-1:0];
      res_b.out_index = idx_ff + IDX_W'(1);
      res_b.out_last  = 1'b1;
      if (full) begin
         res_a.out_byte  = acc[BYTE_W-1:0];
         res_a.out_index = idx_ff;
         res_a.out_last  = s1_last_ff && (rem == 4'd0);
         n_res           = flush ? 2'd2 : 2'd1;
      end else begin
         res_a.out_byte  = rem_acc[BYTE_W-1:0];
         res_a.out_index = idx_ff;
         res_a.out_last  = 1'b1;
         n_res           = flush ? 2'd1 : 2'd0;
      end
   end

   // ------------------------------------------------------------------
   // Result queue, head at entry 0
   // ------------------------------------------------------------------
   rsp_item_type      q_ff [QDEPTH];
   rsp_item_type      q_in [QDEPTH];
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;
   logic              rsp_pop;

   // Room check ignores this cycle's pop: keeps ready off the rsp side.
   assign s1_adv  = s1_valid_ff &&
                    (({1'b0, q_cnt_ff} + {1'b0, n_res}) <= 3'(QDEPTH));
   assign rsp_pop = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      q_in     = q_ff;
      q_cnt_in = q_cnt_ff;
      if (rsp_pop) begin
         q_in[0]  = q_ff[1];
         q_cnt_in = q_cnt_ff - QCNT_W'(1);
      end
      if (s1_adv) begin
         if (n_res != 2'd0) begin
            q_in[q_cnt_in[0]] = res_a;
         end
         if (n_res == 2'd2) begin
            q_in[1] = res_b;
         end
         q_cnt_in = q_cnt_in + n_res;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp_bus.valid     = (q_cnt_ff != '0);
   assign rsp_bus.out_byte  = q_ff[0].out_byte;
   assign rsp_bus.out_index = q_ff[0].out_index;
   assign rsp_bus.out_last  = q_ff[0].out_last;

   // ------------------------------------------------------------------
   // Stream state update
   // ------------------------------------------------------------------
   always_comb begin
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      idx_in      = idx_ff;
      if (s1_adv) begin
         if (s1_last_ff) begin
            pend_in     = '0;
            pend_cnt_in = '0;
            idx_in      = '0;
         end else begin
            pend_in     = rem_acc[PEND_W-1:0];
            pend_cnt_in = rem[PCNT_W-1:0];
            idx_in      = idx_ff + IDX_W'(full);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         q_cnt_ff    <= '0;
         pend_ff     <= '0;
         pend_cnt_ff <= '0;
         idx_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         q_cnt_ff    <= q_cnt_in;
         pend_ff     <= pend_in;
         pend_cnt_ff <= pend_cnt_in;
         idx_ff      <= idx_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");

   a_data_to_s1: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data) |=> s1_valid_ff)
      else $error("accepted data item lost before stage 1");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (pend_cnt_ff == '0 && idx_ff == '0))
      else $error("stream not reset after last item");

   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> ((pend_ff >> pend_cnt_ff) == '0))
      else $error("stale pending bits above count");

endmodule

// ===== tb/masked_bit_compaction_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_bit_compaction_unit_tb
// Self-checking bench for the masked bit compaction unit. A directed table
// covers the corner cases. Random pattern loads and data streams follow.
// Every result item is checked against hand-typed results or an in-bench
// model of the extract-and-pack datapath. Idle cycles are inserted at
// random on both channels.
// ----------------------------------------------------------------------------
module masked_bit_compaction_unit_tb;
   import mbc_pkg::*;

   localparam int CLK_HALF   = 2;
   localparam int RAND_ITEMS = 775;
   localparam int DRAIN_CYC  = 16;

   logic clock;
   logic reset;

   mbc_req_if req_bus ();
   mbc_rsp_if rsp_bus ();

   masked_bit_compaction_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // -------------------------------------------------------------------------
   // Compaction model state
   // -------------------------------------------------------------------------
   logic [BYTE_W-1:0] pattern_mem [BLOCKS];
   bit                loaded_map  [BLOCKS];
   int                loaded_blocks [$];   // blocks safe to read
   logic [PEND_W-1:0] pend_bits;
   logic [PCNT_W-1:0] pend_cnt;
   logic [IDX_W-1:0]  out_idx_next;

   rsp_item_type      compacted_q [$];     // result items still owed by the DUT
   int                err_count;
   int                send_idle_pct;
   int                rcv_idle_pct;

   // -------------------------------------------------------------------------
   // Directed table. Rows with typed_exp set carry their results by hand;
   // the rest take the model's results.
   // -------------------------------------------------------------------------
   typedef struct {
      logic              kind;
      logic [IDX_W-1:0]  blk;
      logic [BYTE_W-1:0] val;
      logic              lst;
      bit                typed_exp;
      int                n_exp;
      rsp_item_type      e0;
      rsp_item_type      e1;
   } stim_row_type;

   localparam int N_ROWS = 25;

   stim_row_type stim_rows [N_ROWS] = '{
      // pattern loads: full, empty (with last set, which is ignored), nibble,
      // top bit only, alternating bits, both block index extremes
      '{KIND_LOAD, 10'd0,    8'hFF, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_LOAD, 10'd1023, 8'h00, 1'b1, 1'b1, 0, '0, '0},
      '{KIND_LOAD, 10'd1,    8'h0F, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_LOAD, 10'd2,    8'h80, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_LOAD, 10'd341,  8'h55, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_LOAD, 10'd682,  8'hAA, 1'b0, 1'b1, 0, '0, '0},
      // full pattern passes the byte straight through
      '{KIND_DATA, 10'd0,    8'hA5, 1'b0, 1'b1, 1, {8'hA5, 10'd0, 1'b0}, '0},
      // last item completes a byte exactly: that byte is the last one
      '{KIND_DATA, 10'd0,    8'h00, 1'b1, 1'b1, 1, {8'h00, 10'd1, 1'b1}, '0},
      // empty pattern on the last item with nothing pending: no output
      '{KIND_DATA, 10'd1023, 8'hFF, 1'b1, 1'b1, 0, '0, '0},
      // two nibbles join into one byte
      '{KIND_DATA, 10'd1,    8'hFF, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd1,    8'h0A, 1'b0, 1'b1, 1, {8'hAF, 10'd0, 1'b0}, '0},
      // one pending bit, then a full byte with last: two results
      '{KIND_DATA, 10'd2,    8'h80, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd0,    8'h00, 1'b1, 1'b1, 2, {8'h01, 10'd1, 1'b0},
                                                   {8'h00, 10'd2, 1'b1}},
      // single-bit partial flush, zeros above the valid bit
      '{KIND_DATA, 10'd2,    8'h7F, 1'b1, 1'b1, 1, {8'h00, 10'd0, 1'b1}, '0},
      // data bits outside the pattern are dropped
      '{KIND_DATA, 10'd341,  8'hFF, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd682,  8'h55, 1'b0, 1'b1, 1, {8'h0F, 10'd0, 1'b0}, '0},
      '{KIND_DATA, 10'd682,  8'hAA, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd0,    8'hFF, 1'b1, 1'b1, 2, {8'hFF, 10'd1, 1'b0},
                                                   {8'h0F, 10'd2, 1'b1}},
      // sparse pattern, model-checked
      '{KIND_LOAD, 10'd963,  8'hC3, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd963,  8'h96, 1'b0, 1'b0, 0, '0, '0},
      '{KIND_DATA, 10'd963,  8'h69, 1'b1, 1'b0, 0, '0, '0},
      // reload a pattern as empty; last item then emits nothing
      '{KIND_LOAD, 10'd0,    8'h00, 1'b1, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd0,    8'h5A, 1'b1, 1'b1, 0, '0, '0},
      // top block with a full pattern
      '{KIND_LOAD, 10'd1023, 8'hFF, 1'b0, 1'b1, 0, '0, '0},
      '{KIND_DATA, 10'd1023, 8'hFF, 1'b0, 1'b1, 1, {8'hFF, 10'd0, 1'b0}, '0}
   };

   // -------------------------------------------------------------------------
   // Clock and reset
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("masked_bit_compaction_unit regression: fail");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Model: applies one accepted item, returns the number of result items
   // -------------------------------------------------------------------------
   function automatic int compact_byte(input logic kind, input logic [IDX_W-1:0] blk,
                                       input logic [BYTE_W-1:0] val, input logic lst,
                                       output rsp_item_type r0, output rsp_item_type r1);
      logic [BYTE_W-1:0] sel;
      logic [BYTE_W-1:0] gathered;
      logic [14:0]       acc;
      rsp_item_type      tail;
      int                n;
      int                total;
      int                k;

      r0 = '0;
      r1 = '0;
      if (kind == KIND_LOAD) begin
         pattern_mem[blk] = val;
         if (!loaded_map[blk]) begin
            loaded_map[blk] = 1'b1;
            loaded_blocks.push_back(int'(blk));
         end
         return 0;
      end

      // gather selected bits, lowest position first
      sel      = pattern_mem[blk];
      gathered = '0;
      n        = 0;
      for (int pos = 0; pos < BYTE_W; pos++) begin
         if (sel[pos]) begin
            gathered[n] = val[pos];
            n++;
         end
      end

      acc   = {8'b0, pend_bits} | (15'(gathered) << pend_cnt);
      total = int'(pend_cnt) + n;
      k     = 0;

      if (total >= BYTE_W) begin
         r0.out_byte  = acc[7:0];
         r0.out_index = out_idx_next;
         r0.out_last  = lst && (total == BYTE_W);
         k            = 1;
         out_idx_next = out_idx_next + 1'b1;   // wraps at 1024
         acc          = acc >> BYTE_W;
         total        = total - BYTE_W;
      end

      if (lst) begin
         if (total > 0) begin
            tail.out_byte  = acc[7:0] & ((8'd1 << total) - 8'd1);
            tail.out_index = out_idx_next;
            tail.out_last  = 1'b1;
            if (k == 0) r0 = tail;
            else        r1 = tail;
            k++;
         end
         pend_bits    = '0;
         pend_cnt     = '0;
         out_idx_next = '0;
      end else begin
         pend_bits = acc[6:0];
         pend_cnt  = total[2:0];
      end
      return k;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: random gap, present the item, hold until accepted, then
   // book the owed results (typed in or from the model)
   // -------------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [IDX_W-1:0] blk,
                            input logic [BYTE_W-1:0] val, input logic lst,
                            input bit typed_exp, input int n_exp,
                            input rsp_item_type e0, input rsp_item_type e1);
      rsp_item_type p0;
      rsp_item_type p1;
      int           n_pred;

      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= kind;
      req_bus.block_index <= blk;
      req_bus.byte_value  <= val;
      req_bus.last        <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);

      // accepted at this edge
      n_pred = compact_byte(kind, blk, val, lst, p0, p1);
      if (typed_exp) begin
         if (n_exp > 0) compacted_q.push_back(e0);
         if (n_exp > 1) compacted_q.push_back(e1);
      end else begin
         if (n_pred > 0) compacted_q.push_back(p0);
         if (n_pred > 1) compacted_q.push_back(p1);
      end
   endtask

   function automatic logic [BYTE_W-1:0] pick_pattern();
      int roll;
      roll = $urandom_range(7);
      if (roll == 0) return 8'h00;
      if (roll == 1) return 8'hFF;
      return BYTE_W'($urandom);
   endfunction

   // Mostly data items against loaded blocks, with pattern loads mixed in
   // and an occasional last to close the stream.
   task automatic random_item();
      logic [IDX_W-1:0] blk;

      if (loaded_blocks.size() == 0 || $urandom_range(99) < 20) begin
         send_item(KIND_LOAD, IDX_W'($urandom), pick_pattern(), 1'($urandom),
                   1'b0, 0, '0, '0);
      end else begin
         blk = IDX_W'(loaded_blocks[$urandom_range(loaded_blocks.size() - 1)]);
         send_item(KIND_DATA, blk, BYTE_W'($urandom), ($urandom_range(15) == 0),
                   1'b0, 0, '0, '0);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result monitor and ready generator
   // -------------------------------------------------------------------------
   task automatic check_rsp();
      rsp_item_type want;

      if (compacted_q.size() == 0) begin
         $error("unexpected result item: out_byte %0h out_index %0d out_last %0b",
                rsp_bus.out_byte, rsp_bus.out_index, rsp_bus.out_last);
         err_count++;
         return;
      end
      want = compacted_q.pop_front();
      if (rsp_bus.out_byte !== want.out_byte) begin
         $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_bus.out_byte);
         err_count++;
      end
      if (rsp_bus.out_index !== want.out_index) begin
         $error("out_index: expected %0d, got %0d", want.out_index, rsp_bus.out_index);
         err_count++;
      end
      if (rsp_bus.out_last !== want.out_last) begin
         $error("out_last: expected %0b, got %0b", want.out_last, rsp_bus.out_last);
         err_count++;
      end
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) check_rsp();
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int k;

      err_count     = 0;
      send_idle_pct = 7;
      rcv_idle_pct  = 46;
      pend_bits     = '0;
      pend_cnt      = '0;
      out_idx_next  = '0;
      foreach (loaded_map[i]) loaded_map[i] = 1'b0;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_LOAD;
      req_bus.block_index <= '0;
      req_bus.byte_value  <= '0;
      req_bus.last        <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corners, sender light / receiver heavy stalls
      for (k = 0; k < N_ROWS; k++) begin
         send_item(stim_rows[k].kind, stim_rows[k].blk, stim_rows[k].val,
                   stim_rows[k].lst, stim_rows[k].typed_exp, stim_rows[k].n_exp,
                   stim_rows[k].e0, stim_rows[k].e1);
      end

      // random traffic in three idle profiles
      for (k = 0; k < RAND_ITEMS; k++) begin
         if (k == RAND_ITEMS / 3) begin
            send_idle_pct = 46;
            rcv_idle_pct  = 7;
         end else if (k == 2 * RAND_ITEMS / 3) begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         random_item();
      end
      req_bus.valid <= 1'b0;

      // drain owed results, then watch for strays
      while (compacted_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      if (err_count == 0 && compacted_q.size() == 0) begin
         $display("masked_bit_compaction_unit regression: pass");
      end else begin
         $display("masked_bit_compaction_unit regression: fail");
      end
      $finish;
   end

endmodule
